[rtl/message_fifo_with_truncation_top_macros.svh]
// ----------------------------------------------------------------------------
// message fifo assertion macros
// shared concurrent check forms for the message fifo
// ----------------------------------------------------------------------------
`ifndef MESSAGE_FIFO_WITH_TRUNCATION_TOP_MACROS_SVH
`define MESSAGE_FIFO_WITH_TRUNCATION_TOP_MACROS_SVH

// condition holds at every edge out of reset
`define MFT_ASSERT_ALWAYS(lbl, ck, rn, cond) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (cond)) \
    else $error("mft: invariant violated");

// antecedent implies consequent in the same cycle
`define MFT_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("mft: implication violated");

// antecedent implies consequent in the next cycle
`define MFT_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("mft: sequence violated");

`endif

[rtl/mft_pkg.sv]
// ----------------------------------------------------------------------------
// mft_pkg
// types and fixed constants of the message fifo
// ----------------------------------------------------------------------------
package mft_pkg;

  localparam int CMD_W         = 3;
  localparam int BYTE_W        = 8;
  localparam int MAX_LEN_W     = 7;
  localparam int MSG_LEN_W     = 6;
  localparam int ENTRY_COUNT_W = 5;
  localparam int DROP_W        = 16;
  localparam logic [MAX_LEN_W-1:0] MAX_RESULTS = 7'd63;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ  = 3'd0,
    CMD_DEQ  = 3'd1,
    CMD_PEEK = 3'd2,
    CMD_CLR  = 3'd3,
    CMD_STAT = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEN,
    S_ZERO,
    S_FETCH,
    S_BYTE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic exec;
    logic start_rd;
    logic take_len;
    logic emit_zero;
    logic emit_byte;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic empty;
    logic cap_zero;
    logic last_byte;
  } sts_t;

endpackage

[rtl/mft_ctrl.sv]
// ----------------------------------------------------------------------------
// mft_ctrl
// sequencer for the message fifo: command dispatch and read streaming
// ----------------------------------------------------------------------------
`include "message_fifo_with_truncation_top_macros.svh"

module mft_ctrl
  import mft_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_cmd,
  output logic             in_ready,
  input  sts_t             sts,
  output ctl_t             ctl
);

  state_t state_r, state_nxt;
  cmd_t   cmd;

  assign cmd = cmd_t'(in_cmd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = sts.out_free;
        if (in_valid && sts.out_free) begin
          if ((cmd == CMD_DEQ || cmd == CMD_PEEK) && !sts.empty) begin
            ctl.start_rd = 1'b1;
            state_nxt    = S_LEN;
          end else begin
            ctl.exec = 1'b1;
          end
        end
      end
      S_LEN: begin
        ctl.take_len = 1'b1;
        state_nxt    = sts.cap_zero ? S_ZERO : S_FETCH;
      end
      S_ZERO: begin
        if (sts.out_free) begin
          ctl.emit_zero = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_FETCH: begin
        state_nxt = S_BYTE;
      end
      S_BYTE: begin
        if (sts.out_free) begin
          ctl.emit_byte = 1'b1;
          state_nxt     = sts.last_byte ? S_IDLE : S_FETCH;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `MFT_ASSERT_NEXT(a_rd_enters_len, clk, rst_n, ctl.start_rd, state_r == S_LEN)
  `MFT_ASSERT_IMPL(a_ready_in_idle, clk, rst_n, in_ready, state_r == S_IDLE)
  `MFT_ASSERT_IMPL(a_one_dispatch, clk, rst_n, ctl.exec, !ctl.start_rd)

endmodule

[rtl/mft_dp.sv]
// ----------------------------------------------------------------------------
// mft_dp
// message fifo datapath: pointers, counters, stores and result register
// ----------------------------------------------------------------------------
`include "message_fifo_with_truncation_top_macros.svh"

module mft_dp
  import mft_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int ENTRY_BYTES = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ctl_t                     ctl,
  output sts_t                     sts,
  input  logic [CMD_W-1:0]         in_cmd,
  input  logic [BYTE_W-1:0]        in_data_byte,
  input  logic                     in_byte_valid,
  input  logic                     in_last,
  input  logic [MAX_LEN_W-1:0]     in_max_length,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_ok,
  output logic [BYTE_W-1:0]        out_byte,
  output logic                     out_byte_valid,
  output logic                     out_last,
  output logic [MSG_LEN_W-1:0]     out_msg_length,
  output logic [ENTRY_COUNT_W-1:0] out_entry_count,
  output logic [DROP_W-1:0]        out_drop_total,
  output logic                     out_is_full,
  output logic                     out_is_empty
);

  localparam int IW       = $clog2(QUEUE_DEPTH);
  localparam int CW       = $clog2(QUEUE_DEPTH + 1);
  localparam int LW       = $clog2(ENTRY_BYTES);
  localparam int AW       = IW + LW;
  localparam int MEM_SIZE = QUEUE_DEPTH * (2 ** LW);

  // stores
  logic [BYTE_W-1:0] msg_mem [MEM_SIZE];
  logic [LW-1:0]     len_mem [QUEUE_DEPTH];

  logic [IW-1:0]        head_r, head_nxt, tail_r, tail_nxt, base_r;
  logic [CW-1:0]        count_r, count_nxt;
  logic [DROP_W-1:0]    drops_r, drops_nxt;
  logic [LW-1:0]        wp_r, wp_nxt, wp_eff, wp_new;
  logic                 in_msg_r, in_msg_nxt, disc_r, disc_nxt;
  logic [MAX_LEN_W-1:0] maxlen_r;
  logic                 remove_r;
  logic [MSG_LEN_W-1:0] len_r, idx_r, idx_nxt, cap_len;
  logic [LW-1:0]        len_rd_r;
  logic [BYTE_W-1:0]    byte_rd_r;
  logic                 wr_en, len_wr_en, load, start, full, out_free;
  logic [AW-1:0]        wr_addr, rd_addr;
  logic [MAX_LEN_W-1:0] len_x, cap_x;
  cmd_t                 cmd;

  logic                     out_valid_r, out_valid_nxt;
  logic                     o_ok_r, o_ok;
  logic [BYTE_W-1:0]        o_byte_r, o_byte;
  logic                     o_bv_r, o_bv;
  logic                     o_last_r, o_last;
  logic [MSG_LEN_W-1:0]     o_len_r, o_len;
  logic [ENTRY_COUNT_W-1:0] o_cnt_r;
  logic [DROP_W-1:0]        o_drop_r;
  logic                     o_full_r, o_empty_r;

  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] v);
    idx_inc = (v == IW'(QUEUE_DEPTH - 1)) ? '0 : v + 1'b1;
  endfunction

  assign cmd      = cmd_t'(in_cmd);
  assign out_free = !out_valid_r || out_ready;
  assign start    = !in_msg_r && !disc_r;
  assign full     = (count_r == CW'(QUEUE_DEPTH));
  assign wp_eff   = start ? '0 : wp_r;
  assign wr_addr  = {tail_r, wp_eff};
  assign rd_addr  = {base_r, LW'(idx_r)};

  // read length cap
  always_comb begin
    len_x = MAX_LEN_W'(len_rd_r);
    if (maxlen_r == '0) begin
      cap_x = '0;
    end else if (len_x >= maxlen_r) begin
      cap_x = maxlen_r - 1'b1;
    end else begin
      cap_x = len_x;
    end
    cap_len = (cap_x > MAX_RESULTS) ? MSG_LEN_W'(MAX_RESULTS) : cap_x[MSG_LEN_W-1:0];
  end

  assign sts.out_free  = out_free;
  assign sts.empty     = (count_r == '0);
  assign sts.cap_zero  = (cap_len == '0);
  assign sts.last_byte = (idx_r == len_r - 1'b1);

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    drops_nxt  = drops_r;
    wp_nxt     = wp_r;
    in_msg_nxt = in_msg_r;
    disc_nxt   = disc_r;
    idx_nxt    = idx_r;
    wp_new     = wp_eff;
    wr_en      = 1'b0;
    len_wr_en  = 1'b0;
    load       = 1'b0;
    o_ok       = 1'b0;
    o_byte     = '0;
    o_bv       = 1'b0;
    o_last     = 1'b1;
    o_len      = '0;
    if (ctl.exec) begin
      load = 1'b1;
      case (cmd)
        CMD_ENQ: begin
          if (disc_r || (start && full)) begin
            if (start && drops_r != '1) begin
              drops_nxt = drops_r + 1'b1;
            end
            disc_nxt = !in_last;
          end else begin
            if (in_byte_valid && wp_eff < LW'(ENTRY_BYTES - 1)) begin
              wr_en  = 1'b1;
              wp_new = wp_eff + 1'b1;
            end
            o_ok  = 1'b1;
            o_len = MSG_LEN_W'(wp_new);
            if (in_last) begin
              len_wr_en  = 1'b1;
              tail_nxt   = idx_inc(tail_r);
              count_nxt  = count_r + 1'b1;
              in_msg_nxt = 1'b0;
              wp_nxt     = '0;
            end else begin
              in_msg_nxt = 1'b1;
              wp_nxt     = wp_new;
            end
          end
        end
        CMD_DEQ, CMD_PEEK: begin
          o_ok = 1'b0;
        end
        CMD_CLR: begin
          head_nxt   = '0;
          tail_nxt   = '0;
          count_nxt  = '0;
          wp_nxt     = '0;
          in_msg_nxt = 1'b0;
          disc_nxt   = 1'b0;
          o_ok       = 1'b1;
        end
        CMD_STAT: begin
          o_ok = 1'b1;
        end
        default: begin
          o_ok = 1'b0;
        end
      endcase
    end
    if (ctl.take_len) begin
      idx_nxt = '0;
      if (remove_r) begin
        head_nxt  = idx_inc(head_r);
        count_nxt = count_r - 1'b1;
      end
    end
    if (ctl.emit_zero) begin
      load = 1'b1;
      o_ok = 1'b1;
    end
    if (ctl.emit_byte) begin
      load    = 1'b1;
      o_ok    = 1'b1;
      o_byte  = byte_rd_r;
      o_bv    = 1'b1;
      o_last  = sts.last_byte;
      o_len   = len_r;
      idx_nxt = idx_r + 1'b1;
    end
    out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      drops_r     <= '0;
      wp_r        <= '0;
      in_msg_r    <= 1'b0;
      disc_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      drops_r     <= drops_nxt;
      wp_r        <= wp_nxt;
      in_msg_r    <= in_msg_nxt;
      disc_r      <= disc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // read context and result payload
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (ctl.start_rd) begin
      maxlen_r <= in_max_length;
      remove_r <= (cmd == CMD_DEQ);
    end
    if (ctl.take_len) begin
      len_r  <= cap_len;
      base_r <= head_r;
    end
    if (load) begin
      o_ok_r    <= o_ok;
      o_byte_r  <= o_byte;
      o_bv_r    <= o_bv;
      o_last_r  <= o_last;
      o_len_r   <= o_len;
      o_cnt_r   <= ENTRY_COUNT_W'(count_nxt);
      o_drop_r  <= drops_nxt;
      o_full_r  <= (count_nxt == CW'(QUEUE_DEPTH));
      o_empty_r <= (count_nxt == '0);
    end
  end

  // stores
  always_ff @(posedge clk) begin
    if (wr_en) begin
      msg_mem[wr_addr] <= in_data_byte;
    end
    byte_rd_r <= msg_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (len_wr_en) begin
      len_mem[tail_r] <= wp_new;
    end
    len_rd_r <= len_mem[head_r];
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = o_ok_r;
  assign out_byte        = o_byte_r;
  assign out_byte_valid  = o_bv_r;
  assign out_last        = o_last_r;
  assign out_msg_length  = o_len_r;
  assign out_entry_count = o_cnt_r;
  assign out_drop_total  = o_drop_r;
  assign out_is_full     = o_full_r;
  assign out_is_empty    = o_empty_r;

  `MFT_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= CW'(QUEUE_DEPTH))
  `MFT_ASSERT_ALWAYS(a_write_or_discard, clk, rst_n, !(in_msg_r && disc_r))
  `MFT_ASSERT_IMPL(a_load_when_free, clk, rst_n, load, out_free)

endmodule

[rtl/message_fifo_with_truncation_top.sv]
// ----------------------------------------------------------------------------
// message_fifo_with_truncation_top
// ring queue of whole messages with drop on full and length truncation
// ----------------------------------------------------------------------------
// usage:
//   in_* carries one command per transaction: enqueue item, dequeue, peek,
//   clear or status. out_* returns results; every command ends with a result
//   that has out_last set.
//   enqueue, clear, status and empty-queue reads: one result, registered in the
//   cycle after acceptance; these leave the controller idle, so enqueue items
//   may follow back to back while the result register is free or drained.
//   dequeue and peek of a stored message: the head length is fetched in S_LEN,
//   then each returned byte passes S_FETCH and S_BYTE (registered read of the
//   message store); a read returning no bytes ends in S_ZERO.
//   a new command is taken once the previous read has streamed out and the
//   result register is free or being drained.
//   reset clears pointers, counts and the drop counter; the stores are not
//   cleared and an entry is read only after it was written.
//   a stalled receiver holds the result register, and the block stops
//   taking commands until the pending result is taken.
// ----------------------------------------------------------------------------
module message_fifo_with_truncation_top
  import mft_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int ENTRY_BYTES = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [CMD_W-1:0]         in_cmd,
  input  logic [BYTE_W-1:0]        in_data_byte,
  input  logic                     in_byte_valid,
  input  logic                     in_last,
  input  logic [MAX_LEN_W-1:0]     in_max_length,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_ok,
  output logic [BYTE_W-1:0]        out_byte,
  output logic                     out_byte_valid,
  output logic                     out_last,
  output logic [MSG_LEN_W-1:0]     out_msg_length,
  output logic [ENTRY_COUNT_W-1:0] out_entry_count,
  output logic [DROP_W-1:0]        out_drop_total,
  output logic                     out_is_full,
  output logic                     out_is_empty
);

  ctl_t ctl;
  sts_t sts;

  mft_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  mft_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ENTRY_BYTES (ENTRY_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .sts             (sts),
    .in_cmd          (in_cmd),
    .in_data_byte    (in_data_byte),
    .in_byte_valid   (in_byte_valid),
    .in_last         (in_last),
    .in_max_length   (in_max_length),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_ok          (out_ok),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_last        (out_last),
    .out_msg_length  (out_msg_length),
    .out_entry_count (out_entry_count),
    .out_drop_total  (out_drop_total),
    .out_is_full     (out_is_full),
    .out_is_empty    (out_is_empty)
  );

endmodule

[dv/message_fifo_with_truncation_top_tb.sv]
// ----------------------------------------------------------------------------
// message_fifo_with_truncation_top_tb
// drives enqueue items, reads, clears and status queries into the message
// fifo with random idling on both sides and a long receiver hold-off, and
// checks every result transaction against a mirror of the queue state
// ----------------------------------------------------------------------------
module message_fifo_with_truncation_top_tb;
  import mft_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int ENTRY_BYTES = 64;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;
  localparam int ITEM_TARGET = 220;

  typedef struct packed {
    cmd_t                 cmd;
    logic [BYTE_W-1:0]    data;
    logic                 bv;
    logic                 last;
    logic [MAX_LEN_W-1:0] maxlen;
  } cmd_item_t;

  typedef struct packed {
    logic                     ok;
    logic [BYTE_W-1:0]        data;
    logic                     bv;
    logic                     last;
    logic [MSG_LEN_W-1:0]     len;
    logic [ENTRY_COUNT_W-1:0] count;
    logic [DROP_W-1:0]        drops;
    logic                     full;
    logic                     empty;
  } res_t;

  class msg_fifo_mirror #(int DEPTH = 16, int ENTRY = 64);
    logic [7:0]  store [DEPTH*ENTRY];
    logic [5:0]  lens [DEPTH];
    int unsigned head = 0;
    int unsigned tail = 0;
    int unsigned count = 0;
    int unsigned wpos = 0;
    logic [15:0] drops = 0;
    bit          in_msg = 0;
    bit          discarding = 0;
    res_t        due_results [$];
    int          errors = 0;

    function void push(bit ok, logic [7:0] b, bit bv, bit last, int unsigned len);
      res_t r;
      r.ok    = ok;
      r.data  = b;
      r.bv    = bv;
      r.last  = last;
      r.len   = len[5:0];
      r.count = count[4:0];
      r.drops = drops;
      r.full  = (count >= DEPTH);
      r.empty = (count == 0);
      due_results.push_back(r);
    endfunction

    function void stream_head(logic [6:0] maxlen, bit remove);
      int unsigned n;
      int unsigned base;
      if (count == 0) begin
        push(0, 0, 0, 1, 0);
        return;
      end
      n = lens[head];
      if (maxlen == 0) n = 0;
      else if (n >= maxlen) n = maxlen - 1;
      if (n > 63) n = 63;
      base = head * ENTRY;
      if (remove) begin
        head = (head + 1) % DEPTH;
        count--;
      end
      if (n == 0) push(1, 0, 0, 1, 0);
      for (int unsigned i = 0; i < n; i++)
        push(1, store[base+i], 1, (i + 1 == n), n);
    endfunction

    function void take_command(cmd_item_t it);
      int unsigned stored;
      case (it.cmd)
        CMD_ENQ: begin
          if (!in_msg && !discarding) begin
            if (count >= DEPTH) begin
              if (drops != 16'hffff) drops++;
              discarding = 1;
            end else begin
              in_msg = 1;
              wpos = 0;
            end
          end
          if (discarding) begin
            if (it.last) discarding = 0;
            push(0, 0, 0, 1, 0);
          end else begin
            if (it.bv && wpos < ENTRY - 1) begin
              store[tail*ENTRY+wpos] = it.data;
              wpos++;
            end
            stored = wpos;
            if (it.last) begin
              lens[tail] = wpos[5:0];
              tail = (tail + 1) % DEPTH;
              count++;
              in_msg = 0;
              wpos = 0;
            end
            push(1, 0, 0, 1, stored);
          end
        end
        CMD_DEQ:  stream_head(it.maxlen, 1);
        CMD_PEEK: stream_head(it.maxlen, 0);
        CMD_CLR: begin
          head = 0;
          tail = 0;
          count = 0;
          wpos = 0;
          in_msg = 0;
          discarding = 0;
          push(1, 0, 0, 1, 0);
        end
        CMD_STAT: push(1, 0, 0, 1, 0);
        default:  push(0, 0, 0, 1, 0);
      endcase
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task match_result(res_t got);
      res_t want;
      if (due_results.size() == 0) begin
        report($sformatf("result transaction with nothing pending: %h", got));
        return;
      end
      want = due_results.pop_front();
      check_field("ok", got.ok, want.ok);
      check_field("out_byte", got.data, want.data);
      check_field("out_byte_valid", got.bv, want.bv);
      check_field("out_last", got.last, want.last);
      check_field("msg_length", got.len, want.len);
      check_field("entry_count", got.count, want.count);
      check_field("drop_total", got.drops, want.drops);
      check_field("is_full", got.full, want.full);
      check_field("is_empty", got.empty, want.empty);
    endtask
  endclass

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [CMD_W-1:0]         in_cmd = CMD_STAT;
  logic [BYTE_W-1:0]        in_data_byte = '0;
  logic                     in_byte_valid = 1'b0;
  logic                     in_last = 1'b0;
  logic [MAX_LEN_W-1:0]     in_max_length = 7'd1;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     out_ok;
  logic [BYTE_W-1:0]        out_byte;
  logic                     out_byte_valid;
  logic                     out_last;
  logic [MSG_LEN_W-1:0]     out_msg_length;
  logic [ENTRY_COUNT_W-1:0] out_entry_count;
  logic [DROP_W-1:0]        out_drop_total;
  logic                     out_is_full;
  logic                     out_is_empty;

  msg_fifo_mirror #(QUEUE_DEPTH, ENTRY_BYTES) mirror;
  int items_sent = 0;
  int stall_run = 0;
  bit in_calm = 0;
  bit out_calm = 0;
  bit hold_off = 0;

  message_fifo_with_truncation_top #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .ENTRY_BYTES(ENTRY_BYTES)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_data_byte   (in_data_byte),
    .in_byte_valid  (in_byte_valid),
    .in_last        (in_last),
    .in_max_length  (in_max_length),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_ok         (out_ok),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_last       (out_last),
    .out_msg_length (out_msg_length),
    .out_entry_count(out_entry_count),
    .out_drop_total (out_drop_total),
    .out_is_full    (out_is_full),
    .out_is_empty   (out_is_empty)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      mirror.take_command(cmd_item_t'{cmd_t'(in_cmd), in_data_byte, in_byte_valid,
                                      in_last, in_max_length});
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      mirror.match_result(res_t'{out_ok, out_byte, out_byte_valid, out_last,
                                 out_msg_length, out_entry_count, out_drop_total,
                                 out_is_full, out_is_empty});
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_run <= 0;
    end else if (stall_run >= STALL_LIMIT) begin
      $display("message_fifo_with_truncation_top test failed");
      $finish;
    end else begin
      stall_run <= stall_run + 1;
    end
  end

  // result side: per-transaction back-pressure, one long hold-off on request
  initial begin : result_sink
    int wait_n;
    do @(posedge clk); while (!rst_n);
    forever begin
      wait_n = out_calm ? 0 : $urandom_range(0, 11);
      if (hold_off) begin
        wait_n = HOLD_CYCLES;
        hold_off = 0;
      end
      if ($urandom_range(0, 19) == 0) out_calm = !out_calm;
      if (wait_n > 0) begin
        out_ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_item(cmd_item_t it);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= it.cmd;
    in_data_byte  <= it.data;
    in_byte_valid <= it.bv;
    in_last       <= it.last;
    in_max_length <= it.maxlen;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_enq(logic [7:0] b, bit bv, bit last);
    send_item('{CMD_ENQ, b, bv, last, 7'($urandom_range(1, 64))});
  endtask

  task automatic send_cmd(cmd_t c, int ml);
    send_item('{c, 8'($urandom), 1'($urandom), 1'($urandom), 7'(ml)});
  endtask

  task automatic send_msg(int n);
    if (n == 0) send_enq(8'($urandom), 0, 1);
    for (int i = 0; i < n; i++)
      send_enq(8'($urandom), $urandom_range(0, 9) != 0, i == n - 1);
  endtask

  function automatic int pick_maxlen();
    if ($urandom_range(0, 3) == 0) return $urandom_range(1, 3);
    return $urandom_range(1, 64);
  endfunction

  initial begin : stimulus
    int n;
    mirror = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty reads, empty message, truncation by reader size, clear
    send_cmd(CMD_STAT, 64);
    send_cmd(CMD_DEQ, 64);
    send_cmd(CMD_PEEK, 1);
    send_enq(8'h00, 0, 1);
    send_cmd(CMD_PEEK, 64);
    send_enq(8'h00, 1, 0);
    send_enq(8'hff, 1, 1);
    send_enq(8'h5a, 1, 0);
    send_enq(8'h00, 0, 0);
    send_enq(8'ha5, 1, 1);
    send_cmd(CMD_PEEK, 1);
    send_cmd(CMD_DEQ, 64);
    send_cmd(CMD_PEEK, 2);
    send_cmd(CMD_DEQ, 64);
    send_cmd(CMD_DEQ, 2);
    send_enq(8'h11, 1, 0);
    send_cmd(CMD_CLR, 64);
    send_cmd(CMD_STAT, 1);
    send_cmd(CMD_DEQ, 64);
    send_enq(8'h7f, 1, 1);
    send_enq(8'h80, 1, 1);
    send_cmd(CMD_DEQ, 1);
    send_cmd(CMD_DEQ, 64);

    // overlong message then fill past full while the receiver holds off
    hold_off = 1;
    send_msg($urandom_range(64, 68));
    repeat (18) send_msg($urandom_range(0, 3));
    send_cmd(CMD_PEEK, 64);

    while (items_sent < ITEM_TARGET) begin
      in_calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 2))
        0: begin
          n = $urandom_range(6, 18);
          repeat (n) begin
            if (items_sent >= ITEM_TARGET) break;
            if ($urandom_range(0, 11) == 0) send_msg($urandom_range(55, 70));
            else send_msg($urandom_range(0, 5));
          end
        end
        1: begin
          n = $urandom_range(6, 18);
          repeat (n) begin
            if (items_sent >= ITEM_TARGET) break;
            send_cmd($urandom_range(0, 3) == 0 ? CMD_PEEK : CMD_DEQ, pick_maxlen());
          end
        end
        default: begin
          n = $urandom_range(8, 20);
          repeat (n) begin
            if (items_sent >= ITEM_TARGET) break;
            case ($urandom_range(0, 9))
              5, 9:    send_cmd(CMD_DEQ, pick_maxlen());
              6:       send_cmd(CMD_PEEK, pick_maxlen());
              7:       send_cmd(CMD_CLR, pick_maxlen());
              8:       send_cmd(CMD_STAT, pick_maxlen());
              default: send_enq(8'($urandom), 1'($urandom_range(0, 1)),
                                $urandom_range(0, 3) == 0);
            endcase
          end
        end
      endcase
    end

    in_valid <= 1'b0;
    while (mirror.due_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mirror.errors == 0 && mirror.due_results.size() == 0)
      $display("message_fifo_with_truncation_top test passed");
    else
      $display("message_fifo_with_truncation_top test failed");
    $finish;
  end

endmodule
